@@ hw/rtl/snoise_pkg.sv @@
// Shared constants, types and helper functions for the 2D simplex noise block.
// No dependencies; imported by simplex_noise_2d, snoise_checker and tb_simplex_noise_2d.
package snoise_pkg;

   localparam int PERM_DEPTH           = 256;
   localparam int IDX_W                = $clog2(PERM_DEPTH);
   localparam int PERM_W               = 8;
   localparam int COORD_W              = 32;
   localparam int NOISE_W              = 16;
   localparam int COORD_FRAC_BITS_DEF  = 16;

   // internal fixed point: offsets in Q28
   localparam int WFRAC = 28;
   localparam int OFF_W = 32;
   localparam logic signed [27:0] F2_Q   = 28'sd98254196;
   localparam logic signed [27:0] G2_Q   = 28'sd56727086;
   localparam logic signed [31:0] ONE_Q  = 32'sh1000_0000;
   localparam logic signed [63:0] HALF_Q56 = 64'sh0080_0000_0000_0000;
   localparam logic signed [41:0] SCALE_70 = 42'sd70;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } opcode_type;

   // byte mod 12 via reciprocal multiply (171/2048), exact for 0..255
   function automatic logic [3:0] mod12(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  rem;
      prod = 16'(v) * 16'd171;
      q    = prod[15:11];
      rem  = v - 8'(q) * 8'd12;
      return rem[3:0];
   endfunction

   // dot product of gradient g with the corner offset
   function automatic logic signed [33:0] grad_dot(input logic [3:0] g,
                                                   input logic signed [31:0] dx,
                                                   input logic signed [31:0] dy);
      logic signed [33:0] ex;
      logic signed [33:0] ey;
      logic signed [33:0] res;
      ex = 34'(dx);
      ey = 34'(dy);
      unique case (g)
         4'd0:    res = ex + ey;
         4'd1:    res = ey - ex;
         4'd2:    res = ex - ey;
         4'd3:    res = -ex - ey;
         4'd4:    res = ex;
         4'd5:    res = -ex;
         4'd6:    res = ex;
         4'd7:    res = -ex;
         4'd8:    res = ey;
         4'd9:    res = -ey;
         4'd10:   res = ey;
         4'd11:   res = -ey;
         default: res = '0;
      endcase
      return res;
   endfunction

   // cell rule: positive -> truncate, otherwise truncate minus one
   function automatic logic signed [61:0] cell_of(input logic signed [61:0] v,
                                                  input int sh);
      logic signed [61:0] neg;
      logic signed [61:0] res;
      neg = -v;
      if (v > 0) begin
         res = v >>> sh;
      end else begin
         res = -(neg >>> sh) - 62'sd1;
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/simplex_noise_2d.sv @@
// Top level of the 2D simplex noise block: pipeline plus permutation tables.
// Depends on snoise_pkg.
//
//  channel | ports                                            | dir
//  req     | req_valid/ready, opcode, x/y_coord, table_idx/val | in
//  rsp     | rsp_valid/ready, rsp_noise_value                  | out
//
// Evaluates: one per cycle while the output side is not stalled; the result passes stage
// regs 1-11, the first loaded at the transfer edge, then the output reg.
// Loads: the table is held as paired bytes {p[k+1],p[k]} so a load writes two byte
// lanes through the one write port, one after the other. A load waits until no second
// lane write is pending and no evaluate sits in stages 1-5 (ahead of the table reads).
// Reset clears valids only; table contents are undefined until loaded.
// Stalls: each stage holds only when it is full and the next one cannot take it.
module simplex_noise_2d #(
   parameter int COORD_FRAC_BITS = snoise_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [snoise_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [snoise_pkg::COORD_W-1:0]  req_y_coord,
   input  logic [snoise_pkg::IDX_W-1:0]           req_table_index,
   input  logic [snoise_pkg::PERM_W-1:0]          req_table_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [snoise_pkg::NOISE_W-1:0]  rsp_noise_value
);
   import snoise_pkg::*;

   localparam int NSTAGE  = 11;
   localparam int CELL_SH = COORD_FRAC_BITS + WFRAC;
   localparam int CELL_W  = 63 - CELL_SH;
   localparam int UP_SH   = WFRAC - COORD_FRAC_BITS;

   // ---------------- handshake and stage control ----------------
   logic [NSTAGE+1:1] en;
   logic [NSTAGE:1]   vld_ff, vld_in;
   logic              rsp_valid_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [PERM_W-1:0] pend_val_ff;
   logic              busy;
   logic              xfer;
   logic              eval_xfer;
   logic              load_xfer;

   assign busy      = |vld_ff[5:1];
   assign req_ready = en[1] && ((req_opcode == OP_EVAL) || (!pend_ff && !busy));
   assign xfer      = req_valid && req_ready;
   assign eval_xfer = xfer && (req_opcode == OP_EVAL);
   assign load_xfer = xfer && (req_opcode == OP_LOAD);

   always_comb begin
      en[NSTAGE+1] = !rsp_valid_ff || rsp_ready;
      for (int k = NSTAGE; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_comb begin
      vld_in[1] = en[1] ? eval_xfer : vld_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         pend_ff <= load_xfer;
         if (en[NSTAGE+1]) begin
            rsp_valid_ff <= vld_ff[NSTAGE];
         end
      end
   end

   // ---------------- permutation tables ----------------
   // word k = {p[k+1], p[k]}; copy a serves the j lookup, copy b the two i lookups
   logic [2*PERM_W-1:0] perm_a_ff [PERM_DEPTH];
   logic [2*PERM_W-1:0] perm_b_ff [PERM_DEPTH];
   logic [IDX_W-1:0]    wr_addr;
   logic [PERM_W-1:0]   wr_data;

   assign wr_addr = pend_ff ? pend_idx_ff : req_table_index;
   assign wr_data = pend_ff ? pend_val_ff : req_table_value;

   always_ff @(posedge clock) begin
      if (load_xfer) begin
         pend_idx_ff <= req_table_index - IDX_W'(1);
         pend_val_ff <= req_table_value;
      end
      if (pend_ff) begin
         perm_a_ff[wr_addr][2*PERM_W-1:PERM_W] <= wr_data;
         perm_b_ff[wr_addr][2*PERM_W-1:PERM_W] <= wr_data;
      end else if (load_xfer) begin
         perm_a_ff[wr_addr][PERM_W-1:0] <= wr_data;
         perm_b_ff[wr_addr][PERM_W-1:0] <= wr_data;
      end
   end

   // ---------------- stage 1: skew product ----------------
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic signed [32:0] sxy;
   logic signed [60:0] skew_in;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_x_ff <= req_x_coord;
         s1_y_ff <= req_y_coord;
      end
   end

   assign sxy     = 33'(s1_x_ff) + 33'(s1_y_ff);
   assign skew_in = 61'(sxy) * 61'(F2_Q);

   // ---------------- stage 2: cell index ----------------
   logic signed [31:0]       s2_x_ff, s2_y_ff;
   logic signed [60:0]       s2_skew_ff;
   logic signed [61:0]       sx, sy, ci_full, cj_full;
   logic signed [CELL_W-1:0] i_in, j_in;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_skew_ff <= skew_in;
      end
   end

   assign sx      = (62'(s2_x_ff) <<< WFRAC) + 62'(s2_skew_ff);
   assign sy      = (62'(s2_y_ff) <<< WFRAC) + 62'(s2_skew_ff);
   assign ci_full = cell_of(sx, CELL_SH);
   assign cj_full = cell_of(sy, CELL_SH);
   assign i_in    = $signed(ci_full[CELL_W-1:0]);
   assign j_in    = $signed(cj_full[CELL_W-1:0]);

   // ---------------- stage 3: unskew product ----------------
   logic signed [31:0]       s3_x_ff, s3_y_ff;
   logic signed [CELL_W-1:0] s3_i_ff, s3_j_ff;
   logic signed [CELL_W:0]   sij;
   logic signed [63:0]       t_prod;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_x_ff <= s2_x_ff;
         s3_y_ff <= s2_y_ff;
         s3_i_ff <= i_in;
         s3_j_ff <= j_in;
      end
   end

   assign sij    = (CELL_W+1)'(s3_i_ff) + (CELL_W+1)'(s3_j_ff);
   assign t_prod = 64'(sij) * 64'(G2_Q);

   // ---------------- stage 4: corner offsets, j lookup ----------------
   logic signed [31:0]       s4_x_ff, s4_y_ff, s4_t_ff;
   logic signed [CELL_W-1:0] s4_i_ff, s4_j_ff;
   logic signed [63:0]       xe, ye;
   logic signed [31:0]       x0, y0;
   logic                     i1_in;
   logic signed [31:0]       off_x_in [3];
   logic signed [31:0]       off_y_in [3];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_x_ff <= s3_x_ff;
         s4_y_ff <= s3_y_ff;
         s4_i_ff <= s3_i_ff;
         s4_j_ff <= s3_j_ff;
         s4_t_ff <= $signed(t_prod[31:0]);
      end
   end

   assign xe    = 64'(s4_x_ff) <<< UP_SH;
   assign ye    = 64'(s4_y_ff) <<< UP_SH;
   assign x0    = $signed(xe[31:0]) - (32'(s4_i_ff) <<< WFRAC) + s4_t_ff;
   assign y0    = $signed(ye[31:0]) - (32'(s4_j_ff) <<< WFRAC) + s4_t_ff;
   assign i1_in = x0 > y0;

   always_comb begin
      off_x_in[0] = x0;
      off_y_in[0] = y0;
      off_x_in[1] = x0 - (i1_in ? ONE_Q : 32'sd0) + 32'(G2_Q);
      off_y_in[1] = y0 - (i1_in ? 32'sd0 : ONE_Q) + 32'(G2_Q);
      off_x_in[2] = x0 - ONE_Q + 32'(G2_Q <<< 1);
      off_y_in[2] = y0 - ONE_Q + 32'(G2_Q <<< 1);
   end

   // ---------------- stage 5: i lookup addresses ----------------
   logic signed [31:0]  s5_ox_ff [3];
   logic signed [31:0]  s5_oy_ff [3];
   logic [IDX_W-1:0]    s5_ii_ff;
   logic                s5_i1_ff;
   logic [2*PERM_W-1:0] rd_a_ff;
   logic [IDX_W-1:0]    addr_b0, addr_b1;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_ox_ff <= off_x_in;
         s5_oy_ff <= off_y_in;
         s5_ii_ff <= s4_i_ff[IDX_W-1:0];
         s5_i1_ff <= i1_in;
         rd_a_ff  <= perm_a_ff[s4_j_ff[IDX_W-1:0]];
      end
   end

   assign addr_b0 = s5_ii_ff + rd_a_ff[PERM_W-1:0];
   assign addr_b1 = s5_ii_ff + rd_a_ff[2*PERM_W-1:PERM_W];

   // ---------------- stage 6: gradients, squares ----------------
   logic signed [31:0]  s6_ox_ff [3];
   logic signed [31:0]  s6_oy_ff [3];
   logic                s6_i1_ff;
   logic [2*PERM_W-1:0] rd_b0_ff, rd_b1_ff;
   logic [PERM_W-1:0]   gbyte [3];
   logic signed [33:0]  dp_in [3];
   logic signed [63:0]  sqx_in [3];
   logic signed [63:0]  sqy_in [3];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_ox_ff <= s5_ox_ff;
         s6_oy_ff <= s5_oy_ff;
         s6_i1_ff <= s5_i1_ff;
         rd_b0_ff <= perm_b_ff[addr_b0];
         rd_b1_ff <= perm_b_ff[addr_b1];
      end
   end

   always_comb begin
      gbyte[0] = rd_b0_ff[PERM_W-1:0];
      gbyte[1] = s6_i1_ff ? rd_b0_ff[2*PERM_W-1:PERM_W] : rd_b1_ff[PERM_W-1:0];
      gbyte[2] = rd_b1_ff[2*PERM_W-1:PERM_W];
      for (int c = 0; c < 3; c++) begin
         dp_in[c]  = grad_dot(mod12(gbyte[c]), s6_ox_ff[c], s6_oy_ff[c]);
         sqx_in[c] = 64'(s6_ox_ff[c]) * 64'(s6_ox_ff[c]);
         sqy_in[c] = 64'(s6_oy_ff[c]) * 64'(s6_oy_ff[c]);
      end
   end

   // ---------------- stage 7: falloff base ----------------
   logic signed [63:0] s7_sqx_ff [3];
   logic signed [63:0] s7_sqy_ff [3];
   logic signed [33:0] s7_dp_ff [3];
   logic signed [63:0] dd [3];
   logic               pos_in [3];
   logic [28:0]        d1_in [3];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_sqx_ff <= sqx_in;
         s7_sqy_ff <= sqy_in;
         s7_dp_ff  <= dp_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dd[c]     = HALF_Q56 - (s7_sqx_ff[c] + s7_sqy_ff[c]);
         pos_in[c] = dd[c] > 0;
         d1_in[c]  = dd[c][54:26];
      end
   end

   // ---------------- stage 8: d squared ----------------
   logic [28:0]        s8_d1_ff [3];
   logic               s8_pos_ff [3];
   logic signed [33:0] s8_dp_ff [3];
   logic [57:0]        d1sq [3];

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_d1_ff  <= d1_in;
         s8_pos_ff <= pos_in;
         s8_dp_ff  <= s7_dp_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         d1sq[c] = 58'(s8_d1_ff[c]) * 58'(s8_d1_ff[c]);
      end
   end

   // ---------------- stage 9: d to the fourth ----------------
   logic [27:0]        s9_d2_ff [3];
   logic               s9_pos_ff [3];
   logic signed [33:0] s9_dp_ff [3];
   logic [55:0]        d2sq [3];

   always_ff @(posedge clock) begin
      if (en[9]) begin
         for (int c = 0; c < 3; c++) begin
            s9_d2_ff[c] <= d1sq[c][57:30];
         end
         s9_pos_ff <= s8_pos_ff;
         s9_dp_ff  <= s8_dp_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         d2sq[c] = 56'(s9_d2_ff[c]) * 56'(s9_d2_ff[c]);
      end
   end

   // ---------------- stage 10: weight times gradient ----------------
   logic [25:0]        s10_d4_ff [3];
   logic               s10_pos_ff [3];
   logic signed [33:0] s10_dp_ff [3];
   logic signed [60:0] wprod [3];
   logic signed [31:0] contrib_in [3];

   always_ff @(posedge clock) begin
      if (en[10]) begin
         for (int c = 0; c < 3; c++) begin
            s10_d4_ff[c] <= d2sq[c][55:30];
         end
         s10_pos_ff <= s9_pos_ff;
         s10_dp_ff  <= s9_dp_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         wprod[c]      = 61'($signed({1'b0, s10_d4_ff[c]})) * 61'(s10_dp_ff[c]);
         contrib_in[c] = s10_pos_ff[c] ? $signed(wprod[c][59:28]) : 32'sd0;
      end
   end

   // ---------------- stage 11: sum, scale, saturate ----------------
   logic signed [31:0]        s11_c_ff [3];
   logic signed [33:0]        csum;
   logic signed [41:0]        scaled;
   logic signed [26:0]        q15;
   logic signed [NOISE_W-1:0] noise_in;
   logic signed [NOISE_W-1:0] rsp_noise_ff;

   always_ff @(posedge clock) begin
      if (en[11]) begin
         s11_c_ff <= contrib_in;
      end
   end

   assign csum   = 34'(s11_c_ff[0]) + 34'(s11_c_ff[1]) + 34'(s11_c_ff[2]);
   assign scaled = 42'(csum) * SCALE_70;
   assign q15    = $signed(scaled[41:15]);

   always_comb begin
      priority if (q15 > 27'sd32767) begin
         noise_in = 16'sh7FFF;
      end else if (q15 < -27'sd32768) begin
         noise_in = 16'sh8000;
      end else begin
         noise_in = $signed(q15[NOISE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTAGE+1]) begin
         rsp_noise_ff <= noise_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

endmodule

@@ sim/snoise_checker.sv @@
// Checker for simplex_noise_2d: watches both channels, mirrors the permutation
// table, predicts every noise sample and compares. Depends on snoise_pkg.
`timescale 1ns / 1ps
module snoise_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [snoise_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [snoise_pkg::COORD_W-1:0]  req_y_coord,
   input  logic [snoise_pkg::IDX_W-1:0]           req_table_index,
   input  logic [snoise_pkg::PERM_W-1:0]          req_table_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [snoise_pkg::NOISE_W-1:0]  rsp_noise_value,
   output int                                     mismatches,
   output int                                     samples_pending
);
   import snoise_pkg::*;

   localparam int FB = COORD_FRAC_BITS_DEF;
   localparam longint ONE = 64'sd1 << 28;
   localparam longint F2 = 64'sd98254196;
   localparam longint G2 = 64'sd56727086;
   localparam longint HALF = 64'sd1 << 55;

   logic [7:0]              perm_mirror [PERM_DEPTH];
   logic signed [15:0]      expected_samples [$];

   initial mismatches = 0;
   initial samples_pending = 0;

   function automatic longint cell_floor(longint v, int n);
      if (v > 0) return v >>> n;
      return -((-v) >>> n) - 1;
   endfunction

   // falloff contribution of one corner, Q30
   function automatic longint falloff(int g, longint dx, longint dy);
      longint d, d1, d2, d4, dp, gx, gy;
      d = HALF - (dx * dx + dy * dy);
      if (d <= 0) return 0;
      gx = (g < 8) ? ((g % 2 == 0) ? 1 : -1) : 0;
      gy = (g < 4) ? ((g < 2) ? 1 : -1) : (g < 8) ? 0 : ((g % 2 == 0) ? 1 : -1);
      d1 = d >>> 26;
      d2 = (d1 * d1) >>> 30;
      d4 = (d2 * d2) >>> 30;
      dp = gx * dx + gy * dy;
      return (d4 * dp) >>> 28;
   endfunction

   function automatic logic signed [15:0] noise_at(logic signed [31:0] xc,
                                                   logic signed [31:0] yc);
      longint x, y, skew, sx, sy, ci, cj, t, x0, y0, x1, y1, x2, y2, i1, j1, sum, r;
      logic [7:0] ii, jj;
      int g0, g1, g2;
      x = xc;
      y = yc;
      skew = (x + y) * F2;
      sx = x * ONE + skew;
      sy = y * ONE + skew;
      ci = cell_floor(sx, FB + 28);
      cj = cell_floor(sy, FB + 28);
      t = (ci + cj) * G2;
      x0 = x * (64'sd1 << (28 - FB)) - (ci * ONE - t);
      y0 = y * (64'sd1 << (28 - FB)) - (cj * ONE - t);
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      x1 = x0 - i1 * ONE + G2;
      y1 = y0 - j1 * ONE + G2;
      x2 = x0 - ONE + 2 * G2;
      y2 = y0 - ONE + 2 * G2;
      ii = ci[7:0];
      jj = cj[7:0];
      g0 = perm_mirror[8'(ii + perm_mirror[jj])] % 12;
      g1 = perm_mirror[8'(ii + 8'(i1) + perm_mirror[8'(jj + 8'(j1))])] % 12;
      g2 = perm_mirror[8'(ii + 8'd1 + perm_mirror[8'(jj + 8'd1)])] % 12;
      sum = falloff(g0, x0, y0) + falloff(g1, x1, y1) + falloff(g2, x2, y2);
      r = (sum * 70) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   task automatic report(string what, logic signed [15:0] got, logic signed [15:0] want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (opcode_type'(req_opcode) == OP_LOAD) begin
               perm_mirror[req_table_index] = req_table_value;
            end else begin
               expected_samples.push_back(noise_at(req_x_coord, req_y_coord));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report("unexpected transfer", rsp_noise_value, 16'sd0);
            end else begin
               if (rsp_noise_value !== expected_samples[0])
                  report("noise_value", rsp_noise_value, expected_samples[0]);
               void'(expected_samples.pop_front());
            end
         end
         samples_pending = expected_samples.size();
      end
   end
endmodule

@@ sim/tb_simplex_noise_2d.sv @@
// Top of the simplex_noise_2d testbench: clock, reset, stimulus and verdict.
// Depends on snoise_pkg, simplex_noise_2d and snoise_checker.
`timescale 1ns / 1ps
module tb_simplex_noise_2d;
   import snoise_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_opcode = OP_LOAD;
   logic signed [COORD_W-1:0]  req_x_coord = '0;
   logic signed [COORD_W-1:0]  req_y_coord = '0;
   logic [IDX_W-1:0]           req_table_index = '0;
   logic [PERM_W-1:0]          req_table_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [NOISE_W-1:0]  rsp_noise_value;
   int                         mismatches;
   int                         samples_pending;
   int                         items_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   simplex_noise_2d i_dut (.*);

   snoise_checker i_checker (.*);

   // offer one item; returns once it has transferred
   task automatic send(opcode_type op, logic signed [31:0] x, logic signed [31:0] y,
                       logic [7:0] idx, logic [7:0] val);
      int gap;
      gap = ((items_sent / 90) % 3 == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_x_coord     <= x;
      req_y_coord     <= y;
      req_table_index <= idx;
      req_table_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic eval_at(logic signed [31:0] x, logic signed [31:0] y);
      send(OP_EVAL, x, y, 8'($urandom), 8'($urandom));
   endtask

   function automatic logic signed [31:0] random_coord();
      int pick;
      pick = $urandom_range(0, 7);
      case (pick)
         0, 1:    return 32'($urandom);
         2, 3, 4: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
         5:       return 32'(($signed($urandom_range(0, 64)) - 32) <<< 16);
         6:       return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                : 32'sh8000_0000 + $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 512)) - 256);
      endcase
   endfunction

   // receiver: random stalls, stretches with none, one long hold-off
   initial begin
      int taken;
      int hold;
      taken = 0;
      @(negedge reset);
      forever begin
         if (taken == 150) hold = 400;
         else if ((taken / 70) % 3 == 1) hold = 0;
         else hold = $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // fill the whole table before the first evaluate
      for (k = 0; k < PERM_DEPTH; k++) send(OP_LOAD, 32'($urandom), 32'($urandom),
                                              8'(k), 8'($urandom));
      send(OP_LOAD, '0, '0, 8'hFF, 8'hFF);
      send(OP_LOAD, '0, '0, 8'h00, 8'h00);
      // directed: origin (skewed zero gives cell minus one), extremes, integral points
      eval_at(32'sd0, 32'sd0);
      eval_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      eval_at(32'sh8000_0000, 32'sh8000_0000);
      eval_at(32'sh7FFF_FFFF, 32'sh8000_0000);
      eval_at(32'sh8000_0000, 32'sh7FFF_FFFF);
      eval_at(32'sd65536, 32'sd0);
      eval_at(-32'sd65536, 32'sd0);
      eval_at(32'sd0, -32'sd1);
      eval_at(32'sd1, -32'sd1);
      eval_at(-32'sd1, 32'sd1);
      eval_at(32'sd65536, 32'sd65536);
      eval_at(-32'sd131072, -32'sd131072);
      eval_at(32'sd32768, 32'sd32768);
      eval_at(32'sd12345, 32'sd54321);
      eval_at(-32'sd1, -32'sd1);
      eval_at(32'sh0100_0000, -32'sh0100_0000);
      // sender pause until every sample is back, then a table rewrite
      req_valid <= 1'b0;
      @(negedge clock);
      wait (samples_pending == 0);
      repeat (15) @(posedge clock);
      send(OP_LOAD, '0, '0, 8'h5A, 8'hA5);
      eval_at(32'sd0, 32'sd0);
      for (k = 0; k < 820; k++) begin
         if ($urandom_range(0, 9) == 0)
            send(OP_LOAD, 32'($urandom), 32'($urandom), 8'($urandom), 8'($urandom));
         else
            eval_at(random_coord(), random_coord());
         if (k == 600) begin
            req_valid <= 1'b0;
            @(negedge clock);
            wait (samples_pending == 0);
            @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(negedge clock);
      wait (samples_pending == 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && samples_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

@@ simplex_noise_2d.f @@
hw/rtl/snoise_pkg.sv
hw/rtl/simplex_noise_2d.sv
sim/snoise_checker.sv
sim/tb_simplex_noise_2d.sv
